// File: hw/rtl/mbsfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbsfl_pkg;

    // fixed field widths of the item and result
    localparam int MODE_W   = 2;
    localparam int BUCKET_W = 6;
    localparam int ENTRY_W  = 10;
    localparam int STATUS_W = 2;
    localparam int HEAD_W   = 11;
    localparam int COUNT_W  = 11;

    // default sizing
    localparam int POOL_SIZE_DEF   = 1024;
    localparam int NUM_BUCKETS_DEF = 64;

    // operation codes, any other code only inspects
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [BUCKET_W-1:0] bucket;
    } cmd_t;

    typedef struct packed {
        logic [ENTRY_W-1:0]  entry_index;
        logic [STATUS_W-1:0] status;
        logic [HEAD_W-1:0]   bucket_head;
        logic                bucket_empty;
        logic [COUNT_W-1:0]  allocated_count;
        logic                pool_full;
    } result_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_POP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic look;
        logic pop_fin;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic pop_go;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/mbsfl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mbsfl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mbsfl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mbsfl_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire mbsfl_pkg::dp_status_t  stat,
    output mbsfl_pkg::ctrl_cmd_t        ctrl,
    output logic                        busy
);

    mbsfl_pkg::state_t state_reg;
    mbsfl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbsfl_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy       = 1'b1;
        case (state_reg)
            mbsfl_pkg::S_CLEAR:
            begin
                ctrl.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = mbsfl_pkg::S_IDLE;
                end
            end
            mbsfl_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = mbsfl_pkg::S_LOOK;
                end
            end
            mbsfl_pkg::S_LOOK:
            begin
                ctrl.look  = 1'b1;
                // a good pop needs one more link read
                state_next = stat.pop_go ? mbsfl_pkg::S_POP : mbsfl_pkg::S_IDLE;
            end
            mbsfl_pkg::S_POP:
            begin
                ctrl.pop_fin = 1'b1;
                state_next   = mbsfl_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mbsfl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/mbsfl_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mbsfl_dp #(
    parameter int POOL_SIZE   = mbsfl_pkg::POOL_SIZE_DEF,
    parameter int NUM_BUCKETS = mbsfl_pkg::NUM_BUCKETS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mbsfl_pkg::ctrl_cmd_t   ctrl,
    input  wire mbsfl_pkg::cmd_t        cmd,
    output mbsfl_pkg::dp_status_t       stat,
    output logic                        done,
    output mbsfl_pkg::result_t          result
);

    localparam int PW  = $clog2(POOL_SIZE + 1);
    localparam int LAW = $clog2(POOL_SIZE);
    localparam int BAW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int EW  = mbsfl_pkg::ENTRY_W;
    localparam int HW  = mbsfl_pkg::HEAD_W;
    localparam int CW  = mbsfl_pkg::COUNT_W;
    localparam logic [PW-1:0]  POOL_PTR    = PW'(POOL_SIZE);
    localparam logic [BAW-1:0] LAST_BUCKET = BAW'(NUM_BUCKETS - 1);

    // control registers
    logic [PW-1:0]  free_top_reg, free_top_next;
    logic [PW-1:0]  hwm_reg, hwm_next;
    logic [PW-1:0]  count_reg, count_next;
    logic [BAW-1:0] clr_cnt_reg, clr_cnt_next;
    logic           done_reg, done_next;

    // payload registers
    logic [mbsfl_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [BAW-1:0]               baddr_reg, baddr_next;
    logic                         valid_reg, valid_next;
    logic [PW-1:0]                btop_reg, btop_next;
    mbsfl_pkg::result_t           out_reg, out_next;

    // memories
    logic           b_we;
    logic [BAW-1:0] b_waddr;
    logic [PW-1:0]  b_wdata;
    logic [PW-1:0]  b_rdata;
    logic           l_we;
    logic [LAW-1:0] l_waddr;
    logic [PW-1:0]  l_wdata;
    logic [LAW-1:0] l_raddr;
    logic [PW-1:0]  l_rdata;

    logic [PW-1:0]  btop_eff;
    logic [PW-1:0]  link_free;
    logic [PW-1:0]  link_pop;
    logic           alloc_ok;
    logic           pop_go;

    logic                           res_load;
    logic [PW-1:0]                  res_entry;
    logic [mbsfl_pkg::STATUS_W-1:0] res_status;
    logic [PW-1:0]                  res_head;
    logic [PW-1:0]                  res_count;
    logic [PW-1:0]                  res_free;

    mbsfl_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (ctrl.capture),
        .raddr (BAW'(cmd.bucket)),
        .rdata (b_rdata)
    );

    mbsfl_ram #(
        .WIDTH (PW),
        .DEPTH (POOL_SIZE)
    ) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (ctrl.capture | ctrl.look),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // entries at or above the high-water mark were never written: link is index plus one
    assign btop_eff  = valid_reg ? b_rdata : POOL_PTR;
    assign link_free = (free_top_reg >= hwm_reg) ? free_top_reg + PW'(1) : l_rdata;
    assign link_pop  = (btop_reg >= hwm_reg) ? btop_reg + PW'(1) : l_rdata;
    assign alloc_ok  = (mode_reg == mbsfl_pkg::MODE_ALLOC) && valid_reg
                       && (free_top_reg < POOL_PTR);
    assign pop_go    = (mode_reg == mbsfl_pkg::MODE_POP) && valid_reg && (b_rdata < POOL_PTR);
    assign l_raddr   = ctrl.look ? b_rdata[LAW-1:0] : free_top_reg[LAW-1:0];

    assign stat.clear_last = (clr_cnt_reg == LAST_BUCKET);
    assign stat.pop_go     = pop_go;

    always_comb
    begin
        free_top_next = free_top_reg;
        hwm_next      = hwm_reg;
        count_next    = count_reg;
        clr_cnt_next  = clr_cnt_reg;
        mode_next     = mode_reg;
        baddr_next    = baddr_reg;
        valid_next    = valid_reg;
        btop_next     = btop_reg;

        b_we    = 1'b0;
        b_waddr = baddr_reg;
        b_wdata = free_top_reg;
        l_we    = 1'b0;
        l_waddr = free_top_reg[LAW-1:0];
        l_wdata = btop_eff;

        res_load   = 1'b0;
        res_entry  = '0;
        res_status = mbsfl_pkg::ST_OK;
        res_head   = btop_eff;
        res_count  = count_reg;
        res_free   = free_top_reg;

        if (ctrl.clear)
        begin
            b_we         = 1'b1;
            b_waddr      = clr_cnt_reg;
            b_wdata      = POOL_PTR;
            clr_cnt_next = clr_cnt_reg + BAW'(1);
        end

        if (ctrl.capture)
        begin
            mode_next  = cmd.mode;
            baddr_next = BAW'(cmd.bucket);
            valid_next = (32'(cmd.bucket) < 32'(NUM_BUCKETS));
        end

        if (ctrl.look)
        begin
            btop_next = b_rdata;
            if (alloc_ok)
            begin
                // push free head onto the bucket
                b_we          = 1'b1;
                l_we          = 1'b1;
                free_top_next = link_free;
                count_next    = count_reg + PW'(1);
                if (free_top_reg == hwm_reg)
                begin
                    hwm_next = hwm_reg + PW'(1);
                end
                res_load  = 1'b1;
                res_entry = free_top_reg;
                res_head  = free_top_reg;
                res_count = count_reg + PW'(1);
                res_free  = link_free;
            end
            else if (!pop_go)
            begin
                res_load = 1'b1;
                if (mode_reg == mbsfl_pkg::MODE_ALLOC)
                begin
                    res_status = mbsfl_pkg::ST_FULL;
                end
                else if (mode_reg == mbsfl_pkg::MODE_POP)
                begin
                    res_status = mbsfl_pkg::ST_EMPTY;
                end
            end
        end

        if (ctrl.pop_fin)
        begin
            // bucket top returns to the head of the free list
            b_we          = 1'b1;
            b_wdata       = link_pop;
            l_we          = 1'b1;
            l_waddr       = btop_reg[LAW-1:0];
            l_wdata       = free_top_reg;
            free_top_next = btop_reg;
            count_next    = count_reg - PW'(1);
            res_load      = 1'b1;
            res_entry     = btop_reg;
            res_head      = link_pop;
            res_count     = count_reg - PW'(1);
            res_free      = btop_reg;
        end

        done_next = res_load;
        out_next  = out_reg;
        if (res_load)
        begin
            out_next.entry_index     = EW'(res_entry);
            out_next.status          = res_status;
            out_next.bucket_head     = HW'(res_head);
            out_next.bucket_empty    = (res_head >= POOL_PTR);
            out_next.allocated_count = CW'(res_count);
            out_next.pool_full       = (res_free >= POOL_PTR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg <= '0;
            hwm_reg      <= '0;
            count_reg    <= '0;
            clr_cnt_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            free_top_reg <= free_top_next;
            hwm_reg      <= hwm_next;
            count_reg    <= count_next;
            clr_cnt_reg  <= clr_cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        baddr_reg <= baddr_next;
        valid_reg <= valid_next;
        btop_reg  <= btop_next;
        out_reg   <= out_next;
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/multi_bucket_stack_free_list.sv
// order: the accepting edge captures the item; the look-up state registers result and done
//   for allocate, inspect and refused items, and the pop-finish state does so for a good pop
// a new item is taken only in idle; a good pop waits on the registered link-memory read
// reset: clears pointers and counts at once, then a clearing pass empties the bucket-top
//   memory with busy held high; link memory needs no pass (high-water mark)
// results are registered and shown for one cycle on done; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module multi_bucket_stack_free_list #(
    parameter int POOL_SIZE   = mbsfl_pkg::POOL_SIZE_DEF,
    parameter int NUM_BUCKETS = mbsfl_pkg::NUM_BUCKETS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire mbsfl_pkg::cmd_t     cmd,
    output logic                     busy,
    output logic                     done,
    output mbsfl_pkg::result_t       result
);

    // command and status between the sequencer and the datapath
    mbsfl_pkg::ctrl_cmd_t ctrl;
    mbsfl_pkg::dp_status_t stat;

    // sequencer: clearing pass, then idle -> look up -> (pop finish) -> idle
    mbsfl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // datapath: bucket-top memory, next-link memory, free head, high-water mark,
    // held count and the result register
    mbsfl_dp #(
        .POOL_SIZE   (POOL_SIZE),
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire
